// File: hdl/sobel_x_gradient_stream_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel x gradient stream core
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_X_GRADIENT_STREAM_CORE_MACROS_SVH
`define SOBEL_X_GRADIENT_STREAM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SXG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SXG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sxg_pkg.sv
// ----------------------------------------------------------------------------
// Sobel x gradient package
// Field widths, register indexes, reset values and the result word type.
// ----------------------------------------------------------------------------
package sxg_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_RESULTS = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic [COL_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic                     is_border;
    } result_t;

    function automatic logic [COL_W-1:0] to_column(input logic [31:0] v);
        return v[COL_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] to_row(input logic [31:0] v);
        return v[ROW_W-1:0];
    endfunction

endpackage

// File: hdl/sobel_x_gradient_stream_core.sv
// ----------------------------------------------------------------------------
// Sobel x gradient stream core
// Horizontal 3x3 Sobel gradient over a raster pixel stream with line stores.
// ----------------------------------------------------------------------------
// The input channel takes one grey pixel per word in raster order; a word is
// taken when in_valid is high and in_stall is low. The output channel gives
// one result word per cycle while out_stall is low, tagged with column, row,
// a border flag and a last flag that marks the final word of one input pixel.
// The configuration channel is always ready; writing image_width or
// image_height restarts the frame at column zero, row zero.
// Each pixel reads both line stores in the cycle it is taken; the pixel waits
// in the internal stage beside the registered read data, and its words are
// loaded into the result slots when that stage moves on to a free output.
// The block takes one pixel per cycle as long as each pixel causes at most one
// word and out_stall is low; the single output word per cycle sets the rate
// otherwise, so the input is stalled on the last row of a frame, where a pixel
// causes up to three words, and at the last column of each row from row one on.
// When the receiver stalls, the held word stays and the input stalls as soon
// as the internal stage fills. Reset sets a 640 by 480 frame and clears the
// counters; the line stores need no clearing pass.
// ----------------------------------------------------------------------------
`include "sobel_x_gradient_stream_core_macros.svh"

module sobel_x_gradient_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [sxg_pkg::PIX_W-1:0]              pixel,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sxg_pkg::GRAD_W-1:0]      gradient,
    output logic [sxg_pkg::COL_W-1:0]              column,
    output logic [sxg_pkg::ROW_W-1:0]              row,
    output logic                                   is_border,
    output logic                                   last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sxg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sxg_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CI = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RI = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int GW = sxg_pkg::GRAD_W;
    localparam int PW = sxg_pkg::PIX_W;

    logic [sxg_pkg::IMG_W_W-1:0] image_width_reg;
    logic [sxg_pkg::IMG_H_W-1:0] image_height_reg;
    logic [CI-1:0]               col_reg, col_next;
    logic [RI-1:0]               row_reg, row_next;

    logic                        s1_valid_reg;
    logic [PW-1:0]               s1_pix_reg;
    logic [CI-1:0]               s1_col_reg;
    logic [RI-1:0]               s1_row_reg;

    logic [PW-1:0]               window_reg [6];

    sxg_pkg::result_t            slot_reg [sxg_pkg::MAX_RESULTS];
    sxg_pkg::result_t            slot_next [sxg_pkg::MAX_RESULTS];
    logic [1:0]                  res_cnt_reg, res_cnt_next;
    logic [1:0]                  res_idx_reg, res_idx_next;

    logic [31:0]                 w_full, h_full;
    logic [WW-1:0]               w_eff, w_m1, col_inc;
    logic [HW-1:0]               h_eff, h_m1, row_inc;
    logic [CI-1:0]               col_cur;
    logic [RI-1:0]               row_cur;

    logic                        cfg_write;
    logic                        in_accept, out_accept, s2_free, s1_go;
    logic                        res_a, res_b, res_d, interior;
    logic [PW-1:0]               top, mid;
    logic [GW-1:0]               grad;
    sxg_pkg::result_t            word_a, word_b, word_d;

    always_comb
    begin
        if (32'(image_width_reg) < 32'd3)
        begin
            w_full = 32'd3;
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_full = 32'(MAX_WIDTH);
        end
        else
        begin
            w_full = 32'(image_width_reg);
        end
        if (32'(image_height_reg) < 32'd3)
        begin
            h_full = 32'd3;
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_full = 32'(MAX_HEIGHT);
        end
        else
        begin
            h_full = 32'(image_height_reg);
        end
    end

    assign w_eff = w_full[WW-1:0];
    assign h_eff = h_full[HW-1:0];
    assign w_m1  = w_eff - WW'(1);
    assign h_m1  = h_eff - HW'(1);

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready &&
                        (cfg_index == sxg_pkg::REG_IMAGE_WIDTH ||
                         cfg_index == sxg_pkg::REG_IMAGE_HEIGHT);

    assign out_valid  = (res_cnt_reg != 2'd0);
    assign last       = out_valid && (res_idx_reg == res_cnt_reg - 2'd1);
    assign out_accept = out_valid && !out_stall;
    assign s2_free    = !out_valid || (out_accept && last);
    assign s1_go      = s1_valid_reg && s2_free;
    assign in_stall   = s1_valid_reg && !s2_free;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        col_cur = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
        row_cur = (HW'(row_reg) >= h_eff) ? '0 : row_reg;
        col_inc = WW'(col_cur) + WW'(1);
        row_inc = HW'(row_cur) + HW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[RI-1:0];
            end
            else
            begin
                col_next = col_inc[CI-1:0];
                row_next = row_cur;
            end
        end
    end

    sxg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (mid)
    );

    sxg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (mid),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (top)
    );

    always_comb
    begin
        res_a    = (s1_row_reg != '0) && (s1_col_reg != '0);
        res_b    = (s1_row_reg != '0) && (WW'(s1_col_reg) == w_m1);
        res_d    = (HW'(s1_row_reg) == h_m1);
        interior = (s1_row_reg > RI'(1)) && (s1_col_reg > CI'(1));

        grad = (GW'(top) - GW'(window_reg[0]))
             + ((GW'(mid) - GW'(window_reg[1])) << 1)
             + (GW'(s1_pix_reg) - GW'(window_reg[2]));

        word_a.gradient  = interior ? grad : '0;
        word_a.column    = sxg_pkg::to_column(32'(s1_col_reg) - 32'd1);
        word_a.row       = sxg_pkg::to_row(32'(s1_row_reg) - 32'd1);
        word_a.is_border = !interior;

        word_b.gradient  = '0;
        word_b.column    = sxg_pkg::to_column(32'(w_m1));
        word_b.row       = sxg_pkg::to_row(32'(s1_row_reg) - 32'd1);
        word_b.is_border = 1'b1;

        word_d.gradient  = '0;
        word_d.column    = sxg_pkg::to_column(32'(s1_col_reg));
        word_d.row       = sxg_pkg::to_row(32'(s1_row_reg));
        word_d.is_border = 1'b1;
    end

    always_comb
    begin
        slot_next    = slot_reg;
        res_cnt_next = res_cnt_reg;
        res_idx_next = res_idx_reg;
        if (s1_go)
        begin
            slot_next[0] = res_a ? word_a : word_d;
            slot_next[1] = res_b ? word_b : word_d;
            slot_next[2] = word_d;
            res_cnt_next = 2'(res_a) + 2'(res_b) + 2'(res_d);
            res_idx_next = 2'd0;
        end
        else if (out_accept)
        begin
            if (last)
            begin
                res_cnt_next = 2'd0;
                res_idx_next = 2'd0;
            end
            else
            begin
                res_idx_next = res_idx_reg + 2'd1;
            end
        end
    end

    assign gradient  = slot_reg[res_idx_reg].gradient;
    assign column    = slot_reg[res_idx_reg].column;
    assign row       = slot_reg[res_idx_reg].row;
    assign is_border = slot_reg[res_idx_reg].is_border;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sxg_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= sxg_pkg::IMAGE_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            res_cnt_reg      <= 2'd0;
            res_idx_reg      <= 2'd0;
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == sxg_pkg::REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data[sxg_pkg::IMG_W_W-1:0];
            end
            if (cfg_valid && cfg_ready && cfg_index == sxg_pkg::REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data[sxg_pkg::IMG_H_W-1:0];
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= res_idx_next;
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                window_reg[0] <= window_reg[3];
                window_reg[1] <= window_reg[4];
                window_reg[2] <= window_reg[5];
                window_reg[3] <= top;
                window_reg[4] <= mid;
                window_reg[5] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg <= pixel;
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
        end
        slot_reg <= slot_next;
    end

    `SXG_ASSERT_SAME(a_idx_in_range, out_valid, res_idx_reg < res_cnt_reg,
        "result index beyond result count")
    `SXG_ASSERT_NEXT(a_last_row_word, s1_go && res_d, out_valid,
        "last row pixel did not produce a word")
    `SXG_ASSERT_SAME(a_no_port_clash, s1_go && in_accept, s1_col_reg != col_cur,
        "line store read and write hit the same entry")
    `SXG_ASSERT_NEXT(a_cfg_restart, cfg_write, col_reg == '0 && row_reg == '0,
        "register write did not restart the frame")

endmodule

// File: hdl/sxg_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module sxg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/tb_sobel_x_gradient_stream_core.sv
// ----------------------------------------------------------------------------
// Testbench for the Sobel x gradient stream core
// Streams grey pixels through frames of many sizes, with random idle bursts
// on the pixel and result channels. Each accepted pixel is run through a
// line-store and window predictor, and every result word is checked field by
// field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_sobel_x_gradient_stream_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN = 1024;
    localparam int MAX_ROWS = 4096;

    localparam logic [sxg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [sxg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic signed [sxg_pkg::GRAD_W-1:0] gradient;
        logic [sxg_pkg::COL_W-1:0]         column;
        logic [sxg_pkg::ROW_W-1:0]         row;
        logic                              is_border;
        logic                              last;
    } gradient_word_t;

    class sobel_x_scoreboard;
        logic [sxg_pkg::IMG_W_W-1:0] width_reg;
        logic [sxg_pkg::IMG_H_W-1:0] height_reg;
        logic [sxg_pkg::PIX_W-1:0]   line_above [LINE_LEN];
        logic [sxg_pkg::PIX_W-1:0]   line_two_above [LINE_LEN];
        logic [sxg_pkg::PIX_W-1:0]   win [6];
        int unsigned                 col_count;
        int unsigned                 row_count;
        gradient_word_t              expected_words [$];
        int                          errors;

        function new();
            width_reg = sxg_pkg::IMAGE_WIDTH_RESET;
            height_reg = sxg_pkg::IMAGE_HEIGHT_RESET;
            foreach (line_above[i])
            begin
                line_above[i] = '0;
                line_two_above[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_count = 0;
            row_count = 0;
            errors = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function gradient_word_t make_word(int g, int unsigned col, int unsigned rw,
                                           logic border);
            gradient_word_t wd;
            wd.gradient = g[sxg_pkg::GRAD_W-1:0];
            wd.column = col[sxg_pkg::COL_W-1:0];
            wd.row = rw[sxg_pkg::ROW_W-1:0];
            wd.is_border = border;
            wd.last = 1'b0;
            return wd;
        endfunction

        function void write_reg(logic [sxg_pkg::CFG_IDX_W-1:0] idx,
                                logic [sxg_pkg::CFG_DATA_W-1:0] data);
            if (idx == sxg_pkg::REG_IMAGE_WIDTH)
                width_reg = data[sxg_pkg::IMG_W_W-1:0];
            else if (idx == sxg_pkg::REG_IMAGE_HEIGHT)
                height_reg = data[sxg_pkg::IMG_H_W-1:0];
            else
                return;
            col_count = 0;
            row_count = 0;
        endfunction

        function void note_pixel(logic [sxg_pkg::PIX_W-1:0] pix);
            int unsigned               w;
            int unsigned               h;
            int unsigned               c;
            int unsigned               r;
            int                        g;
            logic [sxg_pkg::PIX_W-1:0] top;
            logic [sxg_pkg::PIX_W-1:0] mid;
            gradient_word_t            words [$];
            w = clamp_dim(width_reg, LINE_LEN);
            h = clamp_dim(height_reg, MAX_ROWS);
            c = (col_count >= w) ? 0 : col_count;
            r = (row_count >= h) ? 0 : row_count;
            top = line_two_above[c];
            mid = line_above[c];
            if (r >= 1 && c >= 1)
            begin
                if (r >= 2 && c >= 2)
                begin
                    g = (int'(top) - int'(win[0])) + 2 * (int'(mid) - int'(win[1]))
                        + (int'(pix) - int'(win[2]));
                    words.push_back(make_word(g, c - 1, r - 1, 1'b0));
                end
                else
                begin
                    words.push_back(make_word(0, c - 1, r - 1, 1'b1));
                end
            end
            if (r >= 1 && c == w - 1)
                words.push_back(make_word(0, w - 1, r - 1, 1'b1));
            if (r == h - 1)
                words.push_back(make_word(0, c, r, 1'b1));
            if (words.size() != 0)
                words[words.size() - 1].last = 1'b1;
            foreach (words[i])
                expected_words.push_back(words[i]);
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = pix;
            line_two_above[c] = mid;
            line_above[c] = pix;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            col_count = c;
            row_count = r;
        endfunction

        function void check_word(gradient_word_t got);
            gradient_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: column %0d row %0d",
                       got.column, got.row);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.gradient !== want.gradient)
            begin
                $error("gradient mismatch: expected %0d, got %0d", want.gradient, got.gradient);
                errors++;
            end
            if (got.column !== want.column)
            begin
                $error("column mismatch: expected %0d, got %0d", want.column, got.column);
                errors++;
            end
            if (got.row !== want.row)
            begin
                $error("row mismatch: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.is_border !== want.is_border)
            begin
                $error("is_border mismatch: expected %0b, got %0b", want.is_border,
                       got.is_border);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last mismatch: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void flush();
            expected_words.delete();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [sxg_pkg::PIX_W-1:0]           pixel;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [sxg_pkg::GRAD_W-1:0]   gradient;
    logic [sxg_pkg::COL_W-1:0]           column;
    logic [sxg_pkg::ROW_W-1:0]           row;
    logic                                is_border;
    logic                                last;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [sxg_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [sxg_pkg::CFG_DATA_W-1:0]      cfg_data;

    sobel_x_scoreboard board = new();
    int idle_pct = 0;
    int stall_left = 0;

    sobel_x_gradient_stream_core #(
        .MAX_WIDTH(LINE_LEN),
        .MAX_HEIGHT(MAX_ROWS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel(pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .gradient(gradient),
        .column(column),
        .row(row),
        .is_border(is_border),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{gradient, column, row, is_border, last});
        if (stall_left > 0)
            stall_left--;
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            stall_left = $urandom_range(6, 1);
        out_stall <= (stall_left > 0);
    end

    task automatic send_pixel(input logic [sxg_pkg::PIX_W-1:0] p);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pixel(p);
    endtask

    task automatic stream_pixels(input int count);
        logic [sxg_pkg::PIX_W-1:0] p;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: p = '0;
                1: p = '1;
                default: p = sxg_pkg::PIX_W'($urandom);
            endcase
            send_pixel(p);
        end
        in_valid <= 1'b0;
    endtask

    task automatic program_reg(input logic [sxg_pkg::CFG_IDX_W-1:0] idx,
                               input logic [sxg_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while (board.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (board.pending() != 0)
        begin
            $error("%0d result words never arrived", board.pending());
            board.errors++;
            board.flush();
        end
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [sxg_pkg::CFG_DATA_W-1:0] pick_width();
        int unsigned                    w;
        logic [sxg_pkg::CFG_DATA_W-1:0] d;
        case ($urandom_range(7))
            0: w = $urandom_range(2);
            1: w = 3;
            default: w = $urandom_range(12, 3);
        endcase
        d = sxg_pkg::CFG_DATA_W'($urandom);
        d[sxg_pkg::IMG_W_W-1:0] = w[sxg_pkg::IMG_W_W-1:0];
        return d;
    endfunction

    function automatic logic [sxg_pkg::CFG_DATA_W-1:0] pick_height();
        int unsigned h;
        case ($urandom_range(7))
            0: h = $urandom_range(2);
            1: h = $urandom_range(8191);
            default: h = $urandom_range(8, 3);
        endcase
        return h[sxg_pkg::CFG_DATA_W-1:0];
    endfunction

    initial
    begin
        logic [sxg_pkg::PIX_W-1:0] step_frames [18];
        int                        random_items;
        int                        phase;
        int                        n;
        step_frames = '{8'd0, 8'd9, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd77, 8'd255,
                        8'd255, 8'd1, 8'd0, 8'd255, 8'd200, 8'd0, 8'd255, 8'd64, 8'd0};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        pixel <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= sxg_pkg::REG_IMAGE_WIDTH;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        send_pixel('0);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        in_valid <= 1'b0;
        settle();
        program_reg(REG_SPARE_LO, sxg_pkg::CFG_DATA_W'($urandom));
        program_reg(sxg_pkg::REG_IMAGE_WIDTH, 13'd3);
        program_reg(sxg_pkg::REG_IMAGE_HEIGHT, 13'd3);
        foreach (step_frames[i])
            send_pixel(step_frames[i]);
        in_valid <= 1'b0;

        random_items = 0;
        phase = 0;
        while (random_items < 350)
        begin
            settle();
            if (random_items >= 300)
                idle_pct = 0;
            else
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 45;
                endcase
            case ($urandom_range(5))
                0: program_reg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                               sxg_pkg::CFG_DATA_W'($urandom));
                1: program_reg(sxg_pkg::REG_IMAGE_WIDTH, pick_width());
                2: program_reg(sxg_pkg::REG_IMAGE_HEIGHT, pick_height());
                default:
                begin
                    if ($urandom_range(1) != 0)
                    begin
                        program_reg(sxg_pkg::REG_IMAGE_WIDTH, pick_width());
                        program_reg(sxg_pkg::REG_IMAGE_HEIGHT, pick_height());
                    end
                    else
                    begin
                        program_reg(sxg_pkg::REG_IMAGE_HEIGHT, pick_height());
                        program_reg(sxg_pkg::REG_IMAGE_WIDTH, pick_width());
                    end
                end
            endcase
            n = $urandom_range(45, 10);
            stream_pixels(n);
            random_items += n;
            phase++;

            if (phase == 4)
            begin
                idle_pct = 20;
                settle();
                program_reg(sxg_pkg::REG_IMAGE_WIDTH, 13'd1024);
                program_reg(sxg_pkg::REG_IMAGE_HEIGHT, 13'd3);
                stream_pixels(12);
                settle();
                program_reg(sxg_pkg::REG_IMAGE_WIDTH,
                            sxg_pkg::CFG_DATA_W'($urandom_range(2047, 1025)));
                stream_pixels(12);
                settle();
                program_reg(sxg_pkg::REG_IMAGE_WIDTH, 13'd3);
                program_reg(sxg_pkg::REG_IMAGE_HEIGHT, 13'd8191);
                stream_pixels(12);
                settle();
                program_reg(sxg_pkg::REG_IMAGE_HEIGHT, 13'd4096);
                stream_pixels(12);
            end
        end

        settle();
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
